### sv/fxalu_pkg.sv
`timescale 1ns / 1ps
// Types, operation codes and saturation helper for the Q24.8 fixed-point ALU.
// No dependencies.
package fxalu_pkg;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_TO_INT   = 4'd14,
		OP_FROM_INT = 4'd15
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               compare_true;
		logic               overflow;
		logic               divide_by_zero;
	} out_item_t;

	typedef struct packed {
		op_t                op;
		logic               neg;
		logic signed [31:0] res;
		logic               cmp;
		logic               ovf;
		logic               dz;
	} ctl_t;

	typedef struct packed {
		logic signed [31:0] res;
		logic               ovf;
	} sat_t;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// Apply a sign to a magnitude and clamp to the signed 32-bit range.
	function automatic sat_t sat_mag(input logic [63:0] m, input logic neg);
		sat_t s;
		s.ovf = 1'b0;
		if (neg) begin
			if (m > 64'h0000_0000_8000_0000) begin
				s.ovf = 1'b1;
				s.res = S32_MIN;
			end else begin
				s.res = -$signed(m[31:0]);
			end
		end else begin
			if (m > 64'h0000_0000_7FFF_FFFF) begin
				s.ovf = 1'b1;
				s.res = S32_MAX;
			end else begin
				s.res = $signed(m[31:0]);
			end
		end
		return s;
	endfunction

endpackage

### sv/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
// Pipelined signed fixed-point ALU with a bit-per-stage restoring divider.
// Depends on fxalu_pkg.
//
// Usage:
//   Raise start with an item on cmd. The item is taken at any edge where start
//   is high and busy is low; busy is always low, so an item may enter every
//   cycle. Each item yields one result on the result port, marked by done for
//   exactly one cycle, in the order the items entered.
//   Every operation runs through the same pipeline, whose length is set by
//   the divider: one quotient bit per stage over 32 + FRAC_BITS stages,
//   plus an input stage, an operand stage, a divider load stage and a
//   rounding/output stage.
//   Throughput: one item per cycle.
//   Multiply uses one 32x32 multiplier whose product is rounded in the next
//   stage. Multiply and divide round to nearest, ties away from zero; results
//   outside the 32-bit range saturate and set overflow.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall: a result must be taken in its done cycle.
module fixed_point_q24_8_alu #(
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fxalu_pkg::in_item_t  cmd,
	output logic                 done,
	output fxalu_pkg::out_item_t result
);

	localparam int NW  = 32 + FRAC_BITS;
	localparam int LAT = FRAC_BITS + 36;
	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

	typedef struct packed {
		logic [31:0]   rem;
		logic [NW-1:0] num;
		logic [31:0]   den;
		logic [NW-1:0] quo;
	} div_t;

	assign busy = 1'b0;

	// stage 1: input register
	logic                 vld_s1;
	fxalu_pkg::in_item_t  cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
	end

	// stage 2: simple ops and operand magnitudes
	logic signed [31:0] a1, b1;
	logic signed [32:0] sum1, diff1;
	logic signed [31:0] shl1;
	logic [31:0]        mag_a1, mag_b1;
	fxalu_pkg::ctl_t    ctl1;

	assign a1     = cmd_s1.operand_a;
	assign b1     = cmd_s1.operand_b;
	assign sum1   = {a1[31], a1} + {b1[31], b1};
	assign diff1  = {a1[31], a1} - {b1[31], b1};
	assign shl1   = a1 <<< FRAC_BITS;
	assign mag_a1 = a1[31] ? 32'(-a1) : 32'(a1);
	assign mag_b1 = b1[31] ? 32'(-b1) : 32'(b1);

	always_comb begin
		ctl1     = '0;
		ctl1.op  = cmd_s1.op;
		ctl1.neg = a1[31] ^ b1[31];
		unique case (cmd_s1.op)
			fxalu_pkg::OP_ADD: begin
				if (sum1[32] != sum1[31]) begin
					ctl1.ovf = 1'b1;
					ctl1.res = sum1[32] ? fxalu_pkg::S32_MIN : fxalu_pkg::S32_MAX;
				end else begin
					ctl1.res = sum1[31:0];
				end
			end
			fxalu_pkg::OP_SUB: begin
				if (diff1[32] != diff1[31]) begin
					ctl1.ovf = 1'b1;
					ctl1.res = diff1[32] ? fxalu_pkg::S32_MIN : fxalu_pkg::S32_MAX;
				end else begin
					ctl1.res = diff1[31:0];
				end
			end
			fxalu_pkg::OP_MUL: begin
				ctl1.res = '0;
			end
			fxalu_pkg::OP_DIV: begin
				ctl1.dz = (b1 == 32'sd0);
			end
			fxalu_pkg::OP_GT: ctl1.cmp = (a1 > b1);
			fxalu_pkg::OP_LT: ctl1.cmp = (a1 < b1);
			fxalu_pkg::OP_GE: ctl1.cmp = (a1 >= b1);
			fxalu_pkg::OP_LE: ctl1.cmp = (a1 <= b1);
			fxalu_pkg::OP_EQ: ctl1.cmp = (a1 == b1);
			fxalu_pkg::OP_NE: ctl1.cmp = (a1 != b1);
			fxalu_pkg::OP_MIN: ctl1.res = (a1 > b1) ? b1 : a1;
			fxalu_pkg::OP_MAX: ctl1.res = (a1 > b1) ? a1 : b1;
			fxalu_pkg::OP_INC: begin
				if (a1 == fxalu_pkg::S32_MAX) begin
					ctl1.ovf = 1'b1;
					ctl1.res = fxalu_pkg::S32_MAX;
				end else begin
					ctl1.res = a1 + 32'sd1;
				end
			end
			fxalu_pkg::OP_DEC: begin
				if (a1 == fxalu_pkg::S32_MIN) begin
					ctl1.ovf = 1'b1;
					ctl1.res = fxalu_pkg::S32_MIN;
				end else begin
					ctl1.res = a1 - 32'sd1;
				end
			end
			fxalu_pkg::OP_TO_INT: ctl1.res = a1 >>> FRAC_BITS;
			fxalu_pkg::OP_FROM_INT: begin
				if ((shl1 >>> FRAC_BITS) != a1) begin
					ctl1.ovf = 1'b1;
					ctl1.res = a1[31] ? fxalu_pkg::S32_MIN : fxalu_pkg::S32_MAX;
				end else begin
					ctl1.res = shl1;
				end
			end
			default: ctl1.res = '0;
		endcase
	end

	logic            vld_s2;
	fxalu_pkg::ctl_t ctl_s2;
	logic [31:0]     mag_a_s2, mag_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2   <= ctl1;
		mag_a_s2 <= mag_a1;
		mag_b_s2 <= mag_b1;
	end

	// stage 3: product, divider load; then one quotient bit per stage
	logic            vld_ds [NW+1];
	fxalu_pkg::ctl_t ctl_ds [NW+1];
	div_t            div_ds [NW+1];
	logic [63:0]     prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ds[0] <= 1'b0;
		end else begin
			vld_ds[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_ds[0]     <= ctl_s2;
		div_ds[0].rem <= '0;
		div_ds[0].num <= {mag_a_s2, {FRAC_BITS{1'b0}}};
		div_ds[0].den <= mag_b_s2;
		div_ds[0].quo <= '0;
		prod_s3       <= 64'(mag_a_s2) * 64'(mag_b_s2);
	end

	logic [63:0]   mul_mag;
	fxalu_pkg::sat_t mul_sat;

	assign mul_mag = (prod_s3 + HALF) >> FRAC_BITS;
	assign mul_sat = fxalu_pkg::sat_mag(mul_mag, ctl_ds[0].neg);

	for (genvar i = 0; i < NW; i++) begin : g_div
		logic [32:0]     trial;
		logic            ge;
		div_t            nxt;
		fxalu_pkg::ctl_t ctl_nxt;

		assign trial = {div_ds[i].rem, div_ds[i].num[NW-1]};
		assign ge    = trial >= {1'b0, div_ds[i].den};

		always_comb begin
			nxt     = div_ds[i];
			nxt.rem = ge ? 32'(trial - {1'b0, div_ds[i].den}) : trial[31:0];
			nxt.num = div_ds[i].num << 1;
			nxt.quo = {div_ds[i].quo[NW-2:0], ge};
			ctl_nxt = ctl_ds[i];
			if (i == 0 && ctl_ds[i].op == fxalu_pkg::OP_MUL) begin
				ctl_nxt.res = mul_sat.res;
				ctl_nxt.ovf = mul_sat.ovf;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_ds[i+1] <= 1'b0;
			end else begin
				vld_ds[i+1] <= vld_ds[i];
			end
		end

		always_ff @(posedge clk) begin
			div_ds[i+1] <= nxt;
			ctl_ds[i+1] <= ctl_nxt;
		end
	end

	// output stage: round quotient, saturate, merge
	logic              rnd;
	logic [NW:0]       quo_r;
	fxalu_pkg::sat_t   div_sat;
	fxalu_pkg::ctl_t   fin;
	logic              done_q;
	fxalu_pkg::out_item_t result_q;

	assign rnd     = {div_ds[NW].rem, 1'b0} >= {1'b0, div_ds[NW].den};
	assign quo_r   = {1'b0, div_ds[NW].quo} + (NW+1)'(rnd);
	assign div_sat = fxalu_pkg::sat_mag(64'(quo_r), ctl_ds[NW].neg);

	always_comb begin
		fin = ctl_ds[NW];
		if (fin.op == fxalu_pkg::OP_DIV) begin
			if (fin.dz) begin
				fin.res = '0;
				fin.ovf = 1'b0;
			end else begin
				fin.res = div_sat.res;
				fin.ovf = div_sat.ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_ds[NW];
		end
	end

	always_ff @(posedge clk) begin
		result_q.result_value   <= fin.res;
		result_q.compare_true   <= fin.cmp;
		result_q.overflow       <= fin.ovf;
		result_q.divide_by_zero <= fin.dz;
	end

	assign done   = done_q;
	assign result = result_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing at expected latency");

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero |-> result.result_value == 32'sd0 && !result.overflow)
		else $error("divide by zero result not clean");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.compare_true |-> result.result_value == 32'sd0 && !result.overflow)
		else $error("comparison carries a value");

endmodule
